@@ rtl/core/intel_hex_record_encoder_assert.svh @@
// Assertion macros shared by the Intel HEX record encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("intel hex encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("intel hex encoder: next-cycle check failed");

`endif

@@ rtl/core/ihex_pkg.sv @@
// Types, character constants and helper functions of the Intel HEX encoder.
// No dependencies; used by ihex_text_seq and intel_hex_record_encoder.
package ihex_pkg;

  // Configuration register indexes.
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_DUMP_LENGTH   = 1'b1;

  localparam logic [31:0] START_ADDRESS_RST = 32'h0800_0000;
  localparam logic [31:0] DUMP_LENGTH_RST   = 32'h0000_0001;

  // ASCII codes used by the record framing.
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;

  localparam int ELA_LEN = 17;
  localparam int EOF_LEN = 13;

  // ":020000040800F2" CR LF
  localparam logic [6:0] ELA_TEXT [ELA_LEN] = '{
    7'h3A, 7'h30, 7'h32, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h34,
    7'h30, 7'h38, 7'h30, 7'h30, 7'h46, 7'h32, 7'h0D, 7'h0A
  };

  // ":00000001FF" CR LF
  localparam logic [6:0] EOF_TEXT [EOF_LEN] = '{
    7'h3A, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h31,
    7'h46, 7'h46, 7'h0D, 7'h0A
  };

  // Last character index of each fixed-length segment.
  localparam logic [4:0] ELA_LAST  = 5'(ELA_LEN - 1);
  localparam logic [4:0] EOF_LAST  = 5'(EOF_LEN - 1);
  localparam logic [4:0] HDR_LAST  = 5'd8;
  localparam logic [4:0] TAIL_LAST = 5'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELA,
    S_HDR,
    S_BODY,
    S_TAIL,
    S_EOF
  } seq_state_t;

  // One text job: which records to emit and the fields of the data record.
  typedef struct packed {
    logic        ela;
    logic        rec;
    logic        eof;
    logic [4:0]  len;
    logic [15:0] addr;
    logic [7:0]  chk;
  } job_t;

  // Upper-case hex digit of one nibble.
  function automatic logic [6:0] hex_ascii(input logic [3:0] n);
    logic [6:0] code;
    if (n < 4'd10) begin
      code = 7'h30 + {3'b000, n};
    end else begin
      code = 7'h37 + {3'b000, n};
    end
    return code;
  endfunction

endpackage

@@ rtl/core/ihex_text_seq.sv @@
// Character sequencer of the Intel HEX encoder: walks one text job a character
// per cycle unless stalled into a registered output stage. Depends on ihex_pkg.
module ihex_text_seq #(
  parameter int RECORD_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ihex_pkg::job_t        job,
  output logic                  busy,
  output logic [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] rd_idx,
  input  logic [7:0]            rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_text_char,
  output logic                  out_last_of_run
);

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  ihex_pkg::seq_state_t state_r, state_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 nib_r, nib_nxt;
  ihex_pkg::job_t       job_r;
  logic                 out_valid_r;
  logic [6:0]           out_char_r;
  logic                 out_last_r;

  logic       advance;
  logic [6:0] ch;
  logic       is_last;

  assign advance = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nib_nxt   = nib_r;
    ch        = ihex_pkg::CH_ZERO;
    is_last   = 1'b0;
    case (state_r)
      ihex_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = job.ela ? ihex_pkg::S_ELA : ihex_pkg::S_HDR;
          cnt_nxt   = 5'd0;
          nib_nxt   = 1'b0;
        end
      end
      ihex_pkg::S_ELA: begin
        ch      = ihex_pkg::ELA_TEXT[cnt_r];
        is_last = (cnt_r == ihex_pkg::ELA_LAST) && !job_r.rec;
        if (advance) begin
          if (cnt_r == ihex_pkg::ELA_LAST) begin
            cnt_nxt   = 5'd0;
            state_nxt = job_r.rec ? ihex_pkg::S_HDR : ihex_pkg::S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      ihex_pkg::S_HDR: begin
        case (cnt_r)
          5'd0:    ch = ihex_pkg::CH_COLON;
          5'd1:    ch = ihex_pkg::hex_ascii({3'b000, job_r.len[4]});
          5'd2:    ch = ihex_pkg::hex_ascii(job_r.len[3:0]);
          5'd3:    ch = ihex_pkg::hex_ascii(job_r.addr[15:12]);
          5'd4:    ch = ihex_pkg::hex_ascii(job_r.addr[11:8]);
          5'd5:    ch = ihex_pkg::hex_ascii(job_r.addr[7:4]);
          5'd6:    ch = ihex_pkg::hex_ascii(job_r.addr[3:0]);
          default: ch = ihex_pkg::CH_ZERO;
        endcase
        if (advance) begin
          if (cnt_r == ihex_pkg::HDR_LAST) begin
            state_nxt = ihex_pkg::S_BODY;
            cnt_nxt   = 5'd0;
            nib_nxt   = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      ihex_pkg::S_BODY: begin
        ch = ihex_pkg::hex_ascii(nib_r ? rd_data[3:0] : rd_data[7:4]);
        if (advance) begin
          nib_nxt = !nib_r;
          if (nib_r) begin
            if (cnt_r == job_r.len - 5'd1) begin
              state_nxt = ihex_pkg::S_TAIL;
              cnt_nxt   = 5'd0;
            end else begin
              cnt_nxt = cnt_r + 5'd1;
            end
          end
        end
      end
      ihex_pkg::S_TAIL: begin
        case (cnt_r)
          5'd0:    ch = ihex_pkg::hex_ascii(job_r.chk[7:4]);
          5'd1:    ch = ihex_pkg::hex_ascii(job_r.chk[3:0]);
          5'd2:    ch = ihex_pkg::CH_CR;
          default: ch = ihex_pkg::CH_LF;
        endcase
        is_last = (cnt_r == ihex_pkg::TAIL_LAST) && !job_r.eof;
        if (advance) begin
          if (cnt_r == ihex_pkg::TAIL_LAST) begin
            cnt_nxt   = 5'd0;
            state_nxt = job_r.eof ? ihex_pkg::S_EOF : ihex_pkg::S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      ihex_pkg::S_EOF: begin
        ch      = ihex_pkg::EOF_TEXT[cnt_r[3:0]];
        is_last = (cnt_r == ihex_pkg::EOF_LAST);
        if (advance) begin
          if (cnt_r == ihex_pkg::EOF_LAST) begin
            cnt_nxt   = 5'd0;
            state_nxt = ihex_pkg::S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = ihex_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ihex_pkg::S_IDLE;
      cnt_r       <= 5'd0;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nib_r   <= nib_nxt;
      if ((state_r != ihex_pkg::S_IDLE) && advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture the job, load a character on advance.
  always_ff @(posedge clk) begin
    if ((state_r == ihex_pkg::S_IDLE) && start) begin
      job_r <= job;
    end
    if ((state_r != ihex_pkg::S_IDLE) && advance) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign busy            = (state_r != ihex_pkg::S_IDLE);
  assign rd_idx          = cnt_r[IDX_W-1:0];
  assign out_valid       = out_valid_r;
  assign out_text_char   = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

@@ rtl/core/intel_hex_record_encoder.sv @@
// Top level of the Intel HEX record encoder: byte intake, record state and
// configuration. Depends on ihex_pkg, ihex_text_seq and the assert header.
//
// Usage:
//   Input channel in_valid/in_ready/in_data_byte takes one dump byte per item.
//   Output channel out_valid/out_ready carries one ASCII character per item
//   (out_text_char), with out_last_of_run set on the final character caused
//   by one input byte. cfg_we/cfg_index/cfg_wdata writes start_address (0)
//   and dump_length (1); write them only while the block is idle.
// Intake and throughput:
//   An accepted byte updates the record state in its accept cycle. A byte
//   that neither opens a dump nor completes anything leaves in_ready high,
//   so such bytes go in one per cycle. Otherwise the sequencer state is
//   registered, then the first character in the output register, and the
//   sequencer emits one character per cycle while out_ready allows: 17 for
//   the address record, 13 + 2*n for a data record of n bytes, 13 for the
//   end-of-file record. in_ready stays low until the last character of the
//   run is in the output register. A full 16-byte record is 45 characters.
// Reset: rst_n (synchronous, low) empties the open record, restarts the dump
//   count and loads start_address 0x08000000, dump_length 1.
// Stall: while out_valid is high and out_ready is low the output register holds
//   its character and the sequencer waits; nothing is dropped.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_text_char,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  `include "intel_hex_record_encoder_assert.svh"

  localparam int         IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [4:0] FULL  = 5'(RECORD_BYTES);

  // Configuration registers.
  logic [31:0] start_address_r;
  logic [31:0] dump_length_r;

  // Open record state.
  logic [7:0]  buf_r [RECORD_BYTES];
  logic [4:0]  fill_r, fill_nxt;
  logic [31:0] taken_r, taken_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic           accept;
  logic           busy;
  logic           first;
  logic [4:0]     fill_eff;
  logic [4:0]     fill_new;
  logic [15:0]    addr_calc;
  logic [7:0]     sum_base;
  logic [31:0]    taken_after;
  logic           last;
  logic           emit;
  logic           start;
  ihex_pkg::job_t job;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A new dump always opens a fresh record.
    first     = (taken_r == 32'd0);
    fill_eff  = first ? 5'd0 : fill_r;
    addr_calc = start_address_r[15:0] + taken_r[15:0];
    // Capture the address on the first byte of a record; hold it otherwise.
    addr_nxt  = (fill_eff == 5'd0) ? addr_calc : addr_r;
    sum_base  = (fill_eff == 5'd0) ? (addr_nxt[15:8] + addr_nxt[7:0]) : sum_r;
    sum_nxt   = sum_base + in_data_byte;
    fill_new  = fill_eff + 5'd1;

    // Zero length means a full 2^32-byte dump: end on wrap.
    taken_after = taken_r + 32'd1;
    if (dump_length_r == 32'd0) begin
      last = (taken_after == 32'd0);
    end else begin
      last = (taken_after >= dump_length_r);
    end
    emit = (fill_new >= FULL) || last;

    fill_nxt  = emit ? 5'd0 : fill_new;
    taken_nxt = last ? 32'd0 : taken_after;

    job.ela  = first;
    job.rec  = emit;
    job.eof  = last;
    job.len  = fill_new;
    job.addr = addr_nxt;
    job.chk  = 8'd0 - (sum_nxt + {3'b000, fill_new});

    start = accept && (first || emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= ihex_pkg::START_ADDRESS_RST;
      dump_length_r   <= ihex_pkg::DUMP_LENGTH_RST;
      fill_r          <= 5'd0;
      taken_r         <= 32'd0;
      addr_r          <= 16'd0;
      sum_r           <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ihex_pkg::REG_START_ADDRESS: start_address_r <= cfg_wdata;
          ihex_pkg::REG_DUMP_LENGTH:   dump_length_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        fill_r  <= fill_nxt;
        taken_r <= taken_nxt;
        addr_r  <= addr_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  // Record data: write at the fill position, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[fill_eff[IDX_W-1:0]] <= in_data_byte;
    end
  end

  assign rd_data = buf_r[rd_idx];

  ihex_text_seq #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .job             (job),
    .busy            (busy),
    .rd_idx          (rd_idx),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_char   (out_text_char),
    .out_last_of_run (out_last_of_run)
  );

  // Open record never reaches the record size between items.
  `IHEX_ASSERT_NOW(a_fill_below_full, clk, rst_n, 1'b1, fill_r < FULL)
  // A fresh dump count implies an empty open record.
  `IHEX_ASSERT_NOW(a_fresh_dump_empty, clk, rst_n, taken_r == 32'd0, fill_r == 5'd0)
  // The first byte of a dump always starts text and blocks intake.
  `IHEX_ASSERT_NEXT(a_first_byte_busy, clk, rst_n, accept && (taken_r == 32'd0), !in_ready)

endmodule
